### src/pott_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Shared sizes, command codes and result codes for the timer table core.
// ----------------------------------------------------------------------------
package pott_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int MAX_RESULTS = 8;

    localparam int IDX_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int ID_W   = 8;
    localparam int TIME_W = 32;

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_SET    = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_ERR    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

endpackage

### src/periodic_oneshot_timer_table_core.sv
// ----------------------------------------------------------------------------
// Timer table core
// Command-driven table of periodic and one-shot millisecond timers. Interval
// and start time live in two synchronous memories; the flags live in flops.
// ----------------------------------------------------------------------------
// A create, start, stop or set interval request gives its status in the cycle
// after the request; busy stays low, so these can be issued every cycle.
// A tick walks the table one entry per cycle through the memory read port and
// holds busy until the walk ends; results appear during the walk and the final
// one, marked by last, ends it.
// Reset clears the state machine and the per-timer flags; the memories are
// not cleared, since an entry's contents only matter once a create has written it.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_table_core
    import pott_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        command,
    input  logic [ID_W-1:0]   timer_id,
    input  logic [TIME_W-1:0] period_ms,
    input  logic              one_shot,
    input  logic [TIME_W-1:0] now_ms,
    output logic              strobe,
    output logic              kind,
    output logic              status,
    output logic [ID_W-1:0]   expired_id,
    output logic              last
);

    logic [TIME_W-1:0] interval_mem [TIMER_COUNT];
    logic [TIME_W-1:0] start_mem    [TIMER_COUNT];

    state_t                 state_reg, state_next;
    logic [TIMER_COUNT-1:0] enabled_reg, enabled_next;
    logic [TIMER_COUNT-1:0] one_shot_reg, one_shot_next;
    logic [TIMER_COUNT-1:0] created_reg, created_next;

    logic              issue_active_reg, issue_active_next;
    logic [IDX_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] now_reg, now_next;

    logic [TIME_W-1:0] rd_interval_reg;
    logic [TIME_W-1:0] rd_start_reg;

    logic              strobe_reg, strobe_next;
    logic              kind_reg, kind_next;
    logic              status_reg, status_next;
    logic [ID_W-1:0]   expired_id_reg, expired_id_next;
    logic              last_reg, last_next;

    logic              interval_we;
    logic [IDX_W-1:0]  interval_waddr;
    logic [TIME_W-1:0] interval_wdata;
    logic              start_we;
    logic [IDX_W-1:0]  start_waddr;
    logic [TIME_W-1:0] start_wdata;

    logic              id_ok;
    logic [IDX_W-1:0]  cmd_idx;
    logic [TIME_W-1:0] elapsed;
    logic              expire;

    assign id_ok   = timer_id < ID_W'(TIMER_COUNT);
    assign cmd_idx = timer_id[IDX_W-1:0];
    // Elapsed time with 32-bit wrap.
    assign elapsed = now_reg - rd_start_reg;
    assign expire  = chk_valid_reg && enabled_reg[chk_idx_reg] &&
                     (elapsed >= rd_interval_reg);

    always_comb
    begin
        state_next        = state_reg;
        enabled_next      = enabled_reg;
        one_shot_next     = one_shot_reg;
        created_next      = created_reg;
        issue_active_next = issue_active_reg;
        issue_idx_next    = issue_idx_reg;
        chk_valid_next    = chk_valid_reg;
        chk_idx_next      = chk_idx_reg;
        pend_valid_next   = pend_valid_reg;
        pend_idx_next     = pend_idx_reg;
        cnt_next          = cnt_reg;
        now_next          = now_reg;
        strobe_next       = 1'b0;
        kind_next         = kind_reg;
        status_next       = status_reg;
        expired_id_next   = expired_id_reg;
        last_next         = last_reg;
        interval_we       = 1'b0;
        interval_waddr    = cmd_idx;
        interval_wdata    = period_ms;
        start_we          = 1'b0;
        start_waddr       = cmd_idx;
        start_wdata       = now_ms;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_TICK)
                    begin
                        state_next        = ST_SCAN;
                        now_next          = now_ms;
                        issue_active_next = 1'b1;
                        issue_idx_next    = '0;
                        chk_valid_next    = 1'b0;
                        pend_valid_next   = 1'b0;
                        cnt_next          = '0;
                    end
                    else
                    begin
                        strobe_next     = 1'b1;
                        kind_next       = KIND_STATUS;
                        status_next     = STAT_ERR;
                        expired_id_next = '0;
                        last_next       = 1'b1;
                        unique case (command)
                            CMD_CREATE:
                            begin
                                if (id_ok && period_ms != '0)
                                begin
                                    enabled_next[cmd_idx]  = 1'b0;
                                    one_shot_next[cmd_idx] = one_shot;
                                    created_next[cmd_idx]  = 1'b1;
                                    interval_we            = 1'b1;
                                    start_we               = 1'b1;
                                    start_wdata            = '0;
                                    status_next            = STAT_OK;
                                end
                            end
                            CMD_START:
                            begin
                                if (id_ok && created_reg[cmd_idx])
                                begin
                                    enabled_next[cmd_idx] = 1'b1;
                                    start_we              = 1'b1;
                                    status_next           = STAT_OK;
                                end
                            end
                            CMD_STOP:
                            begin
                                if (id_ok)
                                begin
                                    enabled_next[cmd_idx] = 1'b0;
                                    status_next           = STAT_OK;
                                end
                            end
                            CMD_SET:
                            begin
                                if (id_ok && period_ms != '0)
                                begin
                                    interval_we = 1'b1;
                                    status_next = STAT_OK;
                                end
                            end
                            default:
                            begin
                                status_next = STAT_ERR;
                            end
                        endcase
                    end
                end
            end
            ST_SCAN:
            begin
                // Read stage: one table entry per cycle.
                chk_valid_next = issue_active_reg;
                chk_idx_next   = issue_idx_reg;
                if (issue_active_reg)
                begin
                    if (issue_idx_reg == IDX_W'(TIMER_COUNT - 1))
                        issue_active_next = 1'b0;
                    else
                        issue_idx_next = issue_idx_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = ST_FIN;
                end

                // Check stage. An expiry is held in the pending slot until the next one is
                // found, so that the final one can carry last.
                if (expire)
                begin
                    start_we     = 1'b1;
                    start_waddr  = chk_idx_reg;
                    start_wdata  = now_reg;
                    if (one_shot_reg[chk_idx_reg])
                        enabled_next[chk_idx_reg] = 1'b0;
                    if (pend_valid_reg)
                    begin
                        strobe_next     = 1'b1;
                        kind_next       = KIND_EXPIRY;
                        status_next     = STAT_OK;
                        expired_id_next = ID_W'(pend_idx_reg);
                        last_next       = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = chk_idx_reg;
                    cnt_next        = cnt_reg + CNT_W'(1);
                    // Once the result limit is reached the rest of the table
                    // is left untouched for a later tick.
                    if (cnt_reg == CNT_W'(MAX_RESULTS - 1))
                    begin
                        issue_active_next = 1'b0;
                        chk_valid_next    = 1'b0;
                        state_next        = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                strobe_next     = 1'b1;
                status_next     = STAT_OK;
                last_next       = 1'b1;
                if (pend_valid_reg)
                begin
                    kind_next       = KIND_EXPIRY;
                    expired_id_next = ID_W'(pend_idx_reg);
                end
                else
                begin
                    kind_next       = KIND_STATUS;
                    expired_id_next = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (interval_we)
            interval_mem[interval_waddr] <= interval_wdata;
        if (start_we)
            start_mem[start_waddr] <= start_wdata;
        rd_interval_reg <= interval_mem[issue_idx_reg];
        rd_start_reg    <= start_mem[issue_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            enabled_reg      <= '0;
            one_shot_reg     <= '0;
            created_reg      <= '0;
            issue_active_reg <= 1'b0;
            chk_valid_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
            cnt_reg          <= '0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            enabled_reg      <= enabled_next;
            one_shot_reg     <= one_shot_next;
            created_reg      <= created_next;
            issue_active_reg <= issue_active_next;
            chk_valid_reg    <= chk_valid_next;
            pend_valid_reg   <= pend_valid_next;
            cnt_reg          <= cnt_next;
            strobe_reg       <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg  <= issue_idx_next;
        chk_idx_reg    <= chk_idx_next;
        pend_idx_reg   <= pend_idx_next;
        now_reg        <= now_next;
        kind_reg       <= kind_next;
        status_reg     <= status_next;
        expired_id_reg <= expired_id_next;
        last_reg       <= last_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign status     = status_reg;
    assign expired_id = expired_id_reg;
    assign last       = last_reg;

    a_cmd_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command != CMD_TICK) |=> (strobe && last &&
        kind == KIND_STATUS))
        else $error("command request did not give a single status result");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_TICK) |=> (busy && !strobe))
        else $error("tick request did not start a table walk");

    a_expiry_id: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind == KIND_EXPIRY) |-> (expired_id < ID_W'(TIMER_COUNT) &&
        status == STAT_OK))
        else $error("expiry result names a timer outside the table");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("tick produced more expiries than allowed");

    a_fin_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (strobe && last && !busy))
        else $error("table walk did not end with a final result");

endmodule

### tb/sv/tb_periodic_oneshot_timer_table_core.sv
// ----------------------------------------------------------------------------
// Timer table core testbench
// Drives create, start, stop, set interval, tick and unused requests into the
// timer table, keeps a shadow copy of every timer to predict status and expiry
// results, and compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_periodic_oneshot_timer_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pott_pkg::*;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int         PHASE_ITEMS   = 73;
    localparam int         QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic            kind;
        logic            status;
        logic [ID_W-1:0] id;
        logic            last;
    } timer_result_t;

    class timer_table_shadow;
        bit                armed   [TIMER_COUNT];
        bit                single  [TIMER_COUNT];
        bit                made    [TIMER_COUNT];
        logic [TIME_W-1:0] period  [TIMER_COUNT];
        logic [TIME_W-1:0] since   [TIMER_COUNT];
        timer_result_t     due_results[$];
        int                mismatches;

        function new();
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                armed[i]  = 1'b0;
                single[i] = 1'b0;
                made[i]   = 1'b0;
                period[i] = '0;
                since[i]  = '0;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_request(logic [2:0] cmd, logic [ID_W-1:0] id,
                                   logic [TIME_W-1:0] per, logic mode,
                                   logic [TIME_W-1:0] now);
            timer_result_t     res;
            logic [TIME_W-1:0] elapsed;
            logic [IDX_W-1:0]  slot;
            int                fired;
            logic              err;
            fired = 0;
            err   = STAT_ERR;
            slot  = id[IDX_W-1:0];
            if (cmd == CMD_TICK)
            begin
                for (int i = 0; i < TIMER_COUNT && fired < MAX_RESULTS; i++)
                begin
                    elapsed = now - since[i];
                    if (armed[i] && elapsed >= period[i])
                    begin
                        since[i] = now;
                        if (single[i])
                            armed[i] = 1'b0;
                        res = '{KIND_EXPIRY, STAT_OK, ID_W'(i), 1'b0};
                        due_results.push_back(res);
                        fired++;
                    end
                end
                if (fired == 0)
                    due_results.push_back('{KIND_STATUS, STAT_OK, '0, 1'b1});
                else
                    due_results[due_results.size() - 1].last = 1'b1;
                return;
            end
            if (id < ID_W'(TIMER_COUNT))
            begin
                case (cmd)
                    CMD_CREATE:
                        if (per != '0)
                        begin
                            armed[slot]  = 1'b0;
                            single[slot] = mode;
                            period[slot] = per;
                            since[slot]  = '0;
                            made[slot]   = 1'b1;
                            err          = STAT_OK;
                        end
                    CMD_START:
                        if (made[slot])
                        begin
                            since[slot] = now;
                            armed[slot] = 1'b1;
                            err         = STAT_OK;
                        end
                    CMD_STOP:
                    begin
                        armed[slot] = 1'b0;
                        err         = STAT_OK;
                    end
                    CMD_SET:
                        if (per != '0)
                        begin
                            period[slot] = per;
                            err          = STAT_OK;
                        end
                    default:
                        err = STAT_ERR;
                endcase
            end
            due_results.push_back('{KIND_STATUS, err, '0, 1'b1});
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic k, logic s, logic [ID_W-1:0] id, logic l);
            timer_result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: kind %0d status %0d id %0d last %0d expected none, got one",
                         $time, k, s, id, l);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("kind", int'(want.kind), int'(k));
            compare_field("status", int'(want.status), int'(s));
            compare_field("expired_id", int'(want.id), int'(id));
            compare_field("last", int'(want.last), int'(l));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        command;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] period_ms;
    logic              one_shot;
    logic [TIME_W-1:0] now_ms;
    logic              strobe;
    logic              kind;
    logic              status;
    logic [ID_W-1:0]   expired_id;
    logic              last;

    timer_table_shadow shadow = new();
    int                sender_idle_pct;
    int                requests_sent;
    int                quiet_cycles;
    logic [TIME_W-1:0] curr_ms;

    periodic_oneshot_timer_table_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .timer_id   (timer_id),
        .period_ms  (period_ms),
        .one_shot   (one_shot),
        .now_ms     (now_ms),
        .strobe     (strobe),
        .kind       (kind),
        .status     (status),
        .expired_id (expired_id),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            shadow.check_result(kind, status, expired_id, last);
    end

    // Counts cycles in which neither a request nor a result is taken.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("periodic_oneshot_timer_table_core: mismatch");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [2:0] cmd, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] per, input logic mode,
                                input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start     = 1'b1;
        command   = cmd;
        timer_id  = id;
        period_ms = per;
        one_shot  = mode;
        now_ms    = now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow.note_request(cmd, id, per, mode, now);
        requests_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    // Creates and starts every timer, then ticks late enough that all of them fire.
    task automatic arm_all_timers();
        for (int i = 0; i < TIMER_COUNT; i++)
            send_request(CMD_CREATE, ID_W'(i), $urandom_range(1, 6),
                         1'($urandom_range(1)), $urandom);
        for (int i = 0; i < TIMER_COUNT; i++)
            send_request(CMD_START, ID_W'(i), $urandom, 1'($urandom_range(1)), curr_ms);
        curr_ms = curr_ms + 6;
        send_request(CMD_TICK, ID_W'($urandom), $urandom, 1'($urandom_range(1)), curr_ms);
    endtask

    task automatic random_request();
        logic [2:0]        cmd;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] now;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 4)
            cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else if (pick < 16)
            cmd = CMD_CREATE;
        else if (pick < 30)
            cmd = CMD_START;
        else if (pick < 38)
            cmd = CMD_STOP;
        else if (pick < 46)
            cmd = CMD_SET;
        else
            cmd = CMD_TICK;
        id = ($urandom_range(99) < 8) ? ID_W'($urandom_range(TIMER_COUNT, 255))
                                      : ID_W'($urandom_range(TIMER_COUNT - 1));
        pick = $urandom_range(99);
        if (pick < 5)
            per = '0;
        else if (pick < 10)
            per = $urandom;
        else
            per = $urandom_range(1, 24);
        now = curr_ms;
        if (cmd == CMD_TICK)
        begin
            // A few ticks jump to an arbitrary time; the timeline follows them.
            if ($urandom_range(99) < 5)
                curr_ms = $urandom;
            else
                curr_ms = curr_ms + $urandom_range(0, 8);
            now = curr_ms;
            id  = ID_W'($urandom);
            per = $urandom;
        end
        else if ($urandom_range(99) < 10)
            now = $urandom;
        send_request(cmd, id, per, 1'($urandom_range(1)), now);
    endtask

    initial
    begin
        int goal;
        rst_n           = 1'b0;
        start           = 1'b0;
        command         = CMD_STOP;
        timer_id        = '0;
        period_ms       = '0;
        one_shot        = 1'b0;
        now_ms          = '0;
        sender_idle_pct = 0;
        requests_sent   = 0;
        curr_ms         = 32'hFFFF_FF00 + $urandom_range(0, 127);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Requests on timers that were never created.
        send_request(CMD_START, 8'd0, 32'd1, 1'b0, 32'd0);
        send_request(CMD_STOP, 8'd3, 32'd0, 1'b0, 32'd0);
        send_request(CMD_SET, 8'd5, 32'd7, 1'b0, 32'd0);
        send_request(CMD_SET, 8'd5, 32'd0, 1'b0, 32'd0);
        // Bad ids and a zero period, then valid creates and starts.
        send_request(CMD_CREATE, ID_W'(TIMER_COUNT), 32'd5, 1'b0, 32'd0);
        send_request(CMD_CREATE, 8'hFF, 32'd5, 1'b1, 32'hFFFF_FFFF);
        send_request(CMD_CREATE, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(CMD_CREATE, 8'd0, 32'd5, 1'b0, 32'd0);
        send_request(CMD_CREATE, 8'd7, 32'hFFFF_FFFF, 1'b1, 32'd0);
        send_request(CMD_CREATE, 8'd1, 32'd1, 1'b1, 32'd0);
        send_request(CMD_START, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFE);
        send_request(CMD_START, 8'd7, 32'd0, 1'b0, 32'd0);
        send_request(CMD_START, 8'd1, 32'd0, 1'b0, 32'hFFFF_FFFE);
        // Ignored tick fields at their extremes; the second tick wraps the time.
        send_request(CMD_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'd3);
        send_request(CMD_UNUSED_LO, 8'd2, 32'd4, 1'b0, 32'd0);
        send_request(CMD_UNUSED_HI, 8'd2, 32'd4, 1'b1, 32'd0);
        send_request(CMD_STOP, 8'd0, 32'd0, 1'b0, 32'd0);
        send_request(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'd100);
        send_request(CMD_SET, 8'd0, 32'd2, 1'b0, 32'd0);
        send_request(CMD_START, 8'd0, 32'd0, 1'b0, 32'd100);
        send_request(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'd102);
        wait_for_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 71 : 0;
            goal = requests_sent + PHASE_ITEMS;
            while (requests_sent < goal)
            begin
                if ($urandom_range(99) < 4)
                    arm_all_timers();
                else
                    random_request();
            end
            wait_for_results();
        end

        repeat (TIMER_COUNT + 4) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("periodic_oneshot_timer_table_core: match");
        else
            $display("periodic_oneshot_timer_table_core: mismatch");
        $finish;
    end

endmodule
